// ----- design/mcsr_pkg.sv -----
package mcsr_pkg;

   localparam int DEF_SECTOR_BYTES        = 128;
   localparam int DEF_SECTOR_ADDRESS_BITS = 10;

   localparam logic [7:0] FLAG_RESET = 8'h08;

   // host command bytes
   localparam logic [7:0] CMD_PRESENCE = 8'h81;
   localparam logic [7:0] CMD_READ     = 8'h52;
   localparam logic [7:0] CMD_WRITE    = 8'h57;

   // card reply bytes
   localparam logic [7:0] RPL_PRESENCE = 8'hFF;
   localparam logic [7:0] RPL_ID1      = 8'h5A;
   localparam logic [7:0] RPL_ID2      = 8'h5D;
   localparam logic [7:0] RPL_ACK1     = 8'h5C;
   localparam logic [7:0] RPL_ACK2     = 8'h5D;
   localparam logic [7:0] RPL_END      = 8'h47;

   typedef struct packed {
      logic       ack;
      logic [7:0] reply_byte;
   } rsp_type;

endpackage

// ----- design/mcsr_mem.sv -----
module mcsr_mem
   import mcsr_pkg::*;
#(
   parameter int SECTOR_BYTES        = DEF_SECTOR_BYTES,
   parameter int SECTOR_ADDRESS_BITS = DEF_SECTOR_ADDRESS_BITS,
   localparam int OFF_W     = $clog2(SECTOR_BYTES),
   localparam int ADDR_W    = SECTOR_ADDRESS_BITS + OFF_W,
   localparam int MEM_BYTES = SECTOR_BYTES * (1 << SECTOR_ADDRESS_BITS)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data,
   output logic              busy
);

   logic [7:0]        mem_ram [MEM_BYTES];
   logic [7:0]        rd_data_ff;
   logic [ADDR_W-1:0] clr_addr_ff;
   logic [ADDR_W-1:0] clr_addr_in;
   logic              clearing_ff;
   logic              clearing_in;

   // zero fill after reset, one byte per cycle
   always_comb begin
      clr_addr_in = clr_addr_ff;
      clearing_in = clearing_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == ADDR_W'(MEM_BYTES - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         mem_ram[clr_addr_ff] <= 8'h00;
      end else if (wr_en) begin
         mem_ram[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ram[rd_addr];
   end

   assign rd_data = rd_data_ff;
   assign busy    = clearing_ff;

endmodule

// ----- design/mcsr_core.sv -----
module mcsr_core
   import mcsr_pkg::*;
#(
   parameter int SECTOR_BYTES        = DEF_SECTOR_BYTES,
   parameter int SECTOR_ADDRESS_BITS = DEF_SECTOR_ADDRESS_BITS,
   localparam int OFF_W  = $clog2(SECTOR_BYTES),
   localparam int ADDR_W = SECTOR_ADDRESS_BITS + OFF_W
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [7:0]        csr_wr_data,
   input  logic              step,
   input  logic              op,
   input  logic [7:0]        data_in,
   output rsp_type           rsp,
   input  logic [7:0]        mem_rd_data,
   output logic              mem_wr_en,
   output logic [ADDR_W-1:0] mem_wr_addr,
   output logic [7:0]        mem_wr_data,
   output logic [ADDR_W-1:0] mem_rd_addr
);

   localparam logic [4:0] PH_IDLE    = 5'd0;
   localparam logic [4:0] PH_RD_ID1  = 5'd1;
   localparam logic [4:0] PH_RD_ID2  = 5'd2;
   localparam logic [4:0] PH_RD_AMSB = 5'd3;
   localparam logic [4:0] PH_RD_ALSB = 5'd4;
   localparam logic [4:0] PH_RD_ACK1 = 5'd5;
   localparam logic [4:0] PH_RD_ACK2 = 5'd6;
   localparam logic [4:0] PH_RD_EMSB = 5'd7;
   localparam logic [4:0] PH_RD_ELSB = 5'd8;
   localparam logic [4:0] PH_RD_DATA = 5'd9;
   localparam logic [4:0] PH_RD_CHK  = 5'd10;
   localparam logic [4:0] PH_RD_END  = 5'd11;
   localparam logic [4:0] PH_WR_ID1  = 5'd12;
   localparam logic [4:0] PH_WR_ID2  = 5'd13;
   localparam logic [4:0] PH_WR_AMSB = 5'd14;
   localparam logic [4:0] PH_WR_ALSB = 5'd15;
   localparam logic [4:0] PH_WR_DATA = 5'd16;
   localparam logic [4:0] PH_WR_CHK  = 5'd17;
   localparam logic [4:0] PH_WR_ACK1 = 5'd18;
   localparam logic [4:0] PH_WR_ACK2 = 5'd19;
   localparam logic [4:0] PH_WR_END  = 5'd20;

   logic [7:0]                     flag_ff;
   logic [4:0]                     phase_ff;
   logic [4:0]                     phase_in;
   logic [SECTOR_ADDRESS_BITS-1:0] sector_ff;
   logic [SECTOR_ADDRESS_BITS-1:0] sector_in;
   logic [OFF_W-1:0]               offset_ff;
   logic [OFF_W-1:0]               offset_in;
   logic [7:0]                     chk_ff;
   logic [7:0]                     chk_in;
   logic [7:0]                     prev_ff;
   logic [7:0]                     prev_in;

   logic [15:0]       sector16;
   logic [15:0]       sector_tmp;
   logic [7:0]        sum_byte;
   logic [7:0]        chk_add;
   logic              offset_last;
   logic [ADDR_W-1:0] cur_index;
   logic [ADDR_W-1:0] next_index;

   assign sector16    = 16'(sector_ff);
   assign offset_last = offset_ff == OFF_W'(SECTOR_BYTES - 1);
   assign sum_byte    = (phase_ff == PH_RD_DATA) ? mem_rd_data : data_in;
   // first data byte folds in both address bytes
   assign chk_add     = (offset_ff == '0) ? (sector16[15:8] ^ sector16[7:0] ^ sum_byte)
                                          : (chk_ff ^ sum_byte);

   assign cur_index  = ADDR_W'(sector_ff) * ADDR_W'(SECTOR_BYTES) + ADDR_W'(offset_ff);
   assign next_index = ADDR_W'(sector_in) * ADDR_W'(SECTOR_BYTES) + ADDR_W'(offset_in);

   always_comb begin
      phase_in       = phase_ff;
      sector_in      = sector_ff;
      offset_in      = offset_ff;
      chk_in         = chk_ff;
      prev_in        = prev_ff;
      sector_tmp     = sector16;
      rsp.reply_byte = 8'h00;
      rsp.ack        = 1'b1;
      mem_wr_en      = 1'b0;
      if (step) begin
         if (op) begin
            phase_in  = PH_IDLE;
            sector_in = '0;
            offset_in = '0;
            chk_in    = 8'h00;
            prev_in   = 8'h00;
         end else begin
            prev_in = data_in;
            case (phase_ff)
               PH_IDLE: begin
                  if (data_in == CMD_PRESENCE) begin
                     rsp.reply_byte = RPL_PRESENCE;
                  end else if (data_in == CMD_READ) begin
                     rsp.reply_byte = flag_ff;
                     phase_in       = PH_RD_ID1;
                  end else if (data_in == CMD_WRITE) begin
                     rsp.reply_byte = flag_ff;
                     phase_in       = PH_WR_ID1;
                  end else begin
                     rsp.reply_byte = flag_ff;
                     rsp.ack        = 1'b0;
                  end
               end
               PH_RD_ID1: begin
                  rsp.reply_byte = RPL_ID1;
                  phase_in       = PH_RD_ID2;
               end
               PH_RD_ID2: begin
                  rsp.reply_byte = RPL_ID2;
                  phase_in       = PH_RD_AMSB;
               end
               PH_WR_ID1: begin
                  rsp.reply_byte = RPL_ID1;
                  phase_in       = PH_WR_ID2;
               end
               PH_WR_ID2: begin
                  rsp.reply_byte = RPL_ID2;
                  phase_in       = PH_WR_AMSB;
               end
               PH_RD_AMSB, PH_WR_AMSB: begin
                  rsp.reply_byte = 8'h00;
                  sector_tmp     = {data_in, sector16[7:0]};
                  sector_in      = sector_tmp[SECTOR_ADDRESS_BITS-1:0];
                  phase_in       = (phase_ff == PH_RD_AMSB) ? PH_RD_ALSB : PH_WR_ALSB;
               end
               PH_RD_ALSB, PH_WR_ALSB: begin
                  rsp.reply_byte = prev_ff;
                  sector_tmp     = {sector16[15:8], data_in};
                  sector_in      = sector_tmp[SECTOR_ADDRESS_BITS-1:0];
                  offset_in      = '0;
                  phase_in       = (phase_ff == PH_RD_ALSB) ? PH_RD_ACK1 : PH_WR_DATA;
               end
               PH_RD_ACK1: begin
                  rsp.reply_byte = RPL_ACK1;
                  phase_in       = PH_RD_ACK2;
               end
               PH_RD_ACK2: begin
                  rsp.reply_byte = RPL_ACK2;
                  phase_in       = PH_RD_EMSB;
               end
               PH_RD_EMSB: begin
                  rsp.reply_byte = sector16[15:8];
                  phase_in       = PH_RD_ELSB;
               end
               PH_RD_ELSB: begin
                  rsp.reply_byte = sector16[7:0];
                  phase_in       = PH_RD_DATA;
               end
               PH_RD_DATA: begin
                  rsp.reply_byte = mem_rd_data;
                  chk_in         = chk_add;
                  offset_in      = offset_last ? '0 : offset_ff + 1'b1;
                  if (offset_last) begin
                     phase_in = PH_RD_CHK;
                  end
               end
               PH_RD_CHK: begin
                  rsp.reply_byte = chk_ff;
                  phase_in       = PH_RD_END;
               end
               PH_RD_END, PH_WR_END: begin
                  rsp.reply_byte = RPL_END;
                  rsp.ack        = 1'b0;
                  phase_in       = PH_IDLE;
               end
               PH_WR_DATA: begin
                  rsp.reply_byte = prev_ff;
                  chk_in         = chk_add;
                  mem_wr_en      = 1'b1;
                  offset_in      = offset_last ? '0 : offset_ff + 1'b1;
                  if (offset_last) begin
                     phase_in = PH_WR_CHK;
                  end
               end
               PH_WR_CHK: begin
                  rsp.reply_byte = chk_ff;
                  phase_in       = PH_WR_ACK1;
               end
               PH_WR_ACK1: begin
                  rsp.reply_byte = RPL_ACK1;
                  phase_in       = PH_WR_ACK2;
               end
               PH_WR_ACK2: begin
                  rsp.reply_byte = RPL_ACK2;
                  phase_in       = PH_WR_END;
               end
               default: begin
                  phase_in       = PH_IDLE;
                  sector_in      = '0;
                  offset_in      = '0;
                  chk_in         = 8'h00;
                  rsp.reply_byte = flag_ff;
                  rsp.ack        = 1'b0;
               end
            endcase
         end
      end
   end

   // read ahead at the address the next transaction will use
   assign mem_rd_addr = step ? next_index : cur_index;
   assign mem_wr_addr = cur_index;
   assign mem_wr_data = data_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff   <= FLAG_RESET;
         phase_ff  <= PH_IDLE;
         sector_ff <= '0;
         offset_ff <= '0;
         chk_ff    <= 8'h00;
         prev_ff   <= 8'h00;
      end else begin
         if (csr_wr_en) begin
            flag_ff <= csr_wr_data;
         end
         phase_ff  <= phase_in;
         sector_ff <= sector_in;
         offset_ff <= offset_in;
         chk_ff    <= chk_in;
         prev_ff   <= prev_in;
      end
   end

endmodule

// ----- design/memory_card_serial_responder.sv -----
// A request waits in the input register until the output register has room; its reply
// is then registered onto rsp_*. Throughput: one request per cycle while rsp_tready
// is high; the input and output registers decouple the two sides, and the card
// memory is read one transaction ahead so its registered port never stalls the
// stream. A deselect gives no reply. Reset: synchronous; the card memory is then
// zero filled, one byte per cycle, with req_tready low.
module memory_card_serial_responder
   import mcsr_pkg::*;
#(
   parameter int SECTOR_BYTES        = DEF_SECTOR_BYTES,
   parameter int SECTOR_ADDRESS_BITS = DEF_SECTOR_ADDRESS_BITS,
   localparam int OFF_W  = $clog2(SECTOR_BYTES),
   localparam int ADDR_W = SECTOR_ADDRESS_BITS + OFF_W
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_in
   input  logic        req_tuser,   // [0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [7:0] reply_byte, [8] ack, [15:9] zero
);

   logic              in_valid_ff;
   logic              in_valid_in;
   logic              in_op_ff;
   logic [7:0]        in_data_ff;
   logic              out_valid_ff;
   logic              out_valid_in;
   rsp_type           out_ff;
   rsp_type           core_rsp;
   logic              step;
   logic              mem_busy;
   logic              mem_wr_en;
   logic [ADDR_W-1:0] mem_wr_addr;
   logic [7:0]        mem_wr_data;
   logic [ADDR_W-1:0] mem_rd_addr;
   logic [7:0]        mem_rd_data;

   // a deselect needs no room in the output register
   assign step       = in_valid_ff && (in_op_ff || !out_valid_ff || rsp_tready);
   assign req_tready = !mem_busy && (!in_valid_ff || step);

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (step && !in_op_ff) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_op_ff   <= req_tuser;
         in_data_ff <= req_tdata;
      end
      if (step && !in_op_ff) begin
         out_ff <= core_rsp;
      end
   end

   mcsr_core #(
      .SECTOR_BYTES        (SECTOR_BYTES),
      .SECTOR_ADDRESS_BITS (SECTOR_ADDRESS_BITS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .step        (step),
      .op          (in_op_ff),
      .data_in     (in_data_ff),
      .rsp         (core_rsp),
      .mem_rd_data (mem_rd_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_addr (mem_rd_addr)
   );

   mcsr_mem #(
      .SECTOR_BYTES        (SECTOR_BYTES),
      .SECTOR_ADDRESS_BITS (SECTOR_ADDRESS_BITS)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .busy    (mem_busy)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'b0, out_ff.ack, out_ff.reply_byte};

endmodule
